// ----- rtl/crsc_pkg.sv -----
// ----------------------------------------------------------------------------
// crsc_pkg
// Shared types and constants for the clock replacement sector cache.
// ----------------------------------------------------------------------------
package crsc_pkg;

    // Number of cache entries and width of a stored sector number.
    localparam int WAYS        = 64;
    localparam int SECTOR_BITS = 32;

    localparam int WAYS_W = $clog2(WAYS);
    localparam int TAG_W  = (SECTOR_BITS < 32) ? SECTOR_BITS : 32;

    // Fixed field widths of the item ports.
    localparam int WAY_FW = 6;
    localparam int SEC_FW = 32;
    localparam int CNT_W  = 32;

    // Depth of the request queue between front and back.
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_ACCESS = 2'd0,
        OP_INVAL  = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_e_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [SEC_FW-1:0] sector;
        logic              is_write;
    } in_item_t;

    typedef struct packed {
        logic              hit;
        logic [WAY_FW-1:0] way;
        logic              fetch;
        logic [SEC_FW-1:0] fetch_sector;
        logic              write_back;
        logic [SEC_FW-1:0] write_back_sector;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  eviction_writes;
        logic              last;
    } out_item_t;

    // Request as classified by the front part.
    typedef struct packed {
        op_e_t            op;
        logic [TAG_W-1:0] tag;
        logic             is_write;
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CMP,
        ST_SWEEP,
        ST_VICT,
        ST_FSCAN,
        ST_FRD,
        ST_EMIT
    } state_t;

    // Advance a way index with wrap at the last entry.
    function automatic logic [WAYS_W-1:0] way_inc(logic [WAYS_W-1:0] i);
        logic [WAYS_W-1:0] r;
        if (i == WAYS_W'(WAYS - 1)) begin
            r = '0;
        end else begin
            r = i + 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- rtl/crsc_ram.sv -----
// ----------------------------------------------------------------------------
// crsc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module crsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write at the address; read data is registered and appears in the next cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/crsc_front.sv -----
// ----------------------------------------------------------------------------
// crsc_front
// Accepts input items, classifies them and queues them for the back part.
// ----------------------------------------------------------------------------
module crsc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  crsc_pkg::in_item_t  s_item,
    output logic                q_valid,
    output crsc_pkg::req_t      q_req,
    input  logic                q_pop
);

    crsc_pkg::req_t                   q_reg [crsc_pkg::QDEPTH];
    logic [crsc_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [crsc_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [crsc_pkg::QCOUNT_W-1:0]    count_reg;
    logic                             push;
    logic                             pop;
    crsc_pkg::req_t                   new_req;

    assign s_ready = (count_reg != crsc_pkg::QCOUNT_W'(crsc_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_req   = q_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    // Decode the op and trim the sector number to the tag width.
    always_comb begin
        new_req.op       = crsc_pkg::op_e_t'(s_item.op);
        new_req.tag      = crsc_pkg::TAG_W'(s_item.sector);
        new_req.is_write = s_item.is_write;
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= new_req;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == crsc_pkg::QPTR_W'(crsc_pkg::QDEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == crsc_pkg::QPTR_W'(crsc_pkg::QDEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/crsc_back.sv -----
// ----------------------------------------------------------------------------
// crsc_back
// Carries out queued requests: tag search, clock sweep, fill and flush.
// ----------------------------------------------------------------------------
module crsc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  crsc_pkg::req_t      q_req,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output crsc_pkg::out_item_t m_item
);

    localparam int WAYS   = crsc_pkg::WAYS;
    localparam int WAYS_W = crsc_pkg::WAYS_W;
    localparam int TAG_W  = crsc_pkg::TAG_W;

    crsc_pkg::state_t             state_reg, state_next;
    crsc_pkg::req_t               cmd_reg, cmd_next;
    logic [WAYS_W-1:0]            idx_reg, idx_next;
    logic [WAYS_W-1:0]            hand_reg, hand_next;
    logic [WAYS-1:0]              valid_reg, valid_next;
    logic [WAYS-1:0]              dirty_reg, dirty_next;
    logic [WAYS-1:0]              use_reg, use_next;
    logic [crsc_pkg::CNT_W-1:0]   hits_reg, hits_next;
    logic [crsc_pkg::CNT_W-1:0]   wbs_reg, wbs_next;
    crsc_pkg::out_item_t          res_reg, res_next;
    crsc_pkg::out_item_t          out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;

    logic                         ram_we;
    logic [WAYS_W-1:0]            ram_addr;
    logic [TAG_W-1:0]             ram_wdata;
    logic [TAG_W-1:0]             ram_rdata;
    logic [WAYS-1:0]              vd;
    logic [WAYS-1:0]              above;

    crsc_ram #(
        .WIDTH(TAG_W),
        .DEPTH(WAYS)
    ) u_tags (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    // Valid dirty entries after the current index, for the flush last flag.
    assign vd    = valid_reg & dirty_reg;
    assign above = (vd >> idx_reg) >> 1;

    // Next state and datapath control.
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        hand_next      = hand_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        use_next       = use_reg;
        hits_next      = hits_reg;
        wbs_next       = wbs_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = idx_reg;
        ram_wdata      = cmd_reg.tag;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            crsc_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cmd_next = q_req;
                    idx_next = '0;
                    res_next = '0;
                    case (q_req.op)
                        crsc_pkg::OP_ACCESS, crsc_pkg::OP_INVAL: begin
                            state_next = crsc_pkg::ST_SCAN;
                        end
                        crsc_pkg::OP_FLUSH: begin
                            state_next = crsc_pkg::ST_FSCAN;
                        end
                        default: begin
                            valid_next    = '0;
                            dirty_next    = '0;
                            use_next      = '0;
                            hits_next     = '0;
                            wbs_next      = '0;
                            res_next.last = 1'b1;
                            state_next    = crsc_pkg::ST_EMIT;
                        end
                    endcase
                end
            end

            // First tag read of the search is issued at way zero.
            crsc_pkg::ST_SCAN: begin
                ram_addr   = '0;
                state_next = crsc_pkg::ST_CMP;
            end

            // Compare one way a cycle while the next tag is read.
            crsc_pkg::ST_CMP: begin
                ram_addr = crsc_pkg::way_inc(idx_reg);
                if (valid_reg[idx_reg] && (ram_rdata == cmd_reg.tag)) begin
                    hits_next     = hits_reg + 1'b1;
                    res_next.hit  = 1'b1;
                    res_next.way  = crsc_pkg::WAY_FW'(idx_reg);
                    res_next.last = 1'b1;
                    if (cmd_reg.op == crsc_pkg::OP_ACCESS) begin
                        use_next[idx_reg] = 1'b1;
                        if (cmd_reg.is_write) begin
                            dirty_next[idx_reg] = 1'b1;
                        end
                    end else begin
                        valid_next[idx_reg] = 1'b0;
                    end
                    state_next = crsc_pkg::ST_EMIT;
                end else if (idx_reg == WAYS_W'(WAYS - 1)) begin
                    if (cmd_reg.op == crsc_pkg::OP_ACCESS) begin
                        state_next = crsc_pkg::ST_SWEEP;
                    end else begin
                        res_next.last = 1'b1;
                        state_next    = crsc_pkg::ST_EMIT;
                    end
                end else begin
                    idx_next = crsc_pkg::way_inc(idx_reg);
                end
            end

            // Clock hand: give used entries a second chance.
            crsc_pkg::ST_SWEEP: begin
                hand_next = crsc_pkg::way_inc(hand_reg);
                ram_addr  = hand_reg;
                if (valid_reg[hand_reg] && use_reg[hand_reg]) begin
                    use_next[hand_reg] = 1'b0;
                end else begin
                    idx_next   = hand_reg;
                    state_next = crsc_pkg::ST_VICT;
                end
            end

            // Victim tag is in; write back if needed and fill the way.
            crsc_pkg::ST_VICT: begin
                if (valid_reg[idx_reg] && dirty_reg[idx_reg]) begin
                    wbs_next                   = wbs_reg + 1'b1;
                    res_next.write_back        = 1'b1;
                    res_next.write_back_sector = crsc_pkg::SEC_FW'(ram_rdata);
                end
                ram_we              = 1'b1;
                valid_next[idx_reg] = 1'b1;
                use_next[idx_reg]   = 1'b1;
                dirty_next[idx_reg] = cmd_reg.is_write;
                res_next.way          = crsc_pkg::WAY_FW'(idx_reg);
                res_next.fetch        = 1'b1;
                res_next.fetch_sector = crsc_pkg::SEC_FW'(cmd_reg.tag);
                res_next.last         = 1'b1;
                state_next            = crsc_pkg::ST_EMIT;
            end

            // Flush: step to the next valid dirty way.
            crsc_pkg::ST_FSCAN: begin
                if (vd[idx_reg]) begin
                    state_next = crsc_pkg::ST_FRD;
                end else if (idx_reg == WAYS_W'(WAYS - 1)) begin
                    state_next = crsc_pkg::ST_IDLE;
                end else begin
                    idx_next = crsc_pkg::way_inc(idx_reg);
                end
            end

            crsc_pkg::ST_FRD: begin
                res_next                   = '0;
                res_next.way               = crsc_pkg::WAY_FW'(idx_reg);
                res_next.write_back        = 1'b1;
                res_next.write_back_sector = crsc_pkg::SEC_FW'(ram_rdata);
                res_next.last              = (above == '0);
                state_next                 = crsc_pkg::ST_EMIT;
            end

            // Hand the result item to the output register.
            crsc_pkg::ST_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    out_next                 = res_reg;
                    out_next.hit_total       = hits_reg;
                    out_next.eviction_writes = wbs_reg;
                    out_valid_next           = 1'b1;
                    if (cmd_reg.op == crsc_pkg::OP_FLUSH && !res_reg.last) begin
                        idx_next   = crsc_pkg::way_inc(idx_reg);
                        state_next = crsc_pkg::ST_FSCAN;
                    end else begin
                        state_next = crsc_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = crsc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= crsc_pkg::ST_IDLE;
            hand_reg      <= '0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            use_reg       <= '0;
            hits_reg      <= '0;
            wbs_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hand_reg      <= hand_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            use_reg       <= use_next;
            hits_reg      <= hits_next;
            wbs_reg       <= wbs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

endmodule

// ----- rtl/clock_replacement_sector_cache.sv -----
// ----------------------------------------------------------------------------
// clock_replacement_sector_cache
// Tag and clock replacement controller for a fully associative sector cache.
// ----------------------------------------------------------------------------
// Items are queued by the front part and executed one at a time by the back
// part. Tags live in a single-port RAM, so a lookup compares one way per
// cycle and stops at the first hit; a miss then lets the clock hand sweep to
// a victim. A flush steps through every way and reports each valid dirty
// entry, and a clear resets the valid, dirty and use bits and both counters.
// The output register lets the back part start the next item while a result
// waits to be taken.
module clock_replacement_sector_cache (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  crsc_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output crsc_pkg::out_item_t m_item
);

    logic           q_valid;
    logic           q_pop;
    crsc_pkg::req_t q_req;

    crsc_front u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .q_valid(q_valid),
        .q_req  (q_req),
        .q_pop  (q_pop)
    );

    crsc_back u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_valid(q_valid),
        .q_req  (q_req),
        .q_pop  (q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

endmodule

// ----- verif/clock_replacement_sector_cache_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_replacement_sector_cache_tb
// Self-checking bench: a queue-fed driver offers access, invalidate, flush
// and clear items with random gaps, a predictor of the clock replacement
// policy computes the expected results, and a monitor compares each result.
// ----------------------------------------------------------------------------
module clock_replacement_sector_cache_tb;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    crsc_pkg::in_item_t  s_item;
    logic                m_valid;
    logic                m_ready;
    crsc_pkg::out_item_t m_item;

    clock_replacement_sector_cache u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Predictor state of the cache.
    logic [31:0] tags [64];
    logic [63:0] vld;
    logic [63:0] drt;
    logic [63:0] usd;
    logic [5:0]  hand;
    logic [31:0] hits;
    logic [31:0] wbacks;

    crsc_pkg::in_item_t  pending_items [$];
    crsc_pkg::out_item_t expected_results [$];
    int                  fail_count;
    bit                  stim_done;
    int                  hold_cycles;
    int                  gap_cycles;
    int                  stall_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic crsc_pkg::out_item_t blank_result();
        crsc_pkg::out_item_t r;
        r = '0;
        r.hit_total = hits;
        r.eviction_writes = wbacks;
        r.last = 1'b1;
        return r;
    endfunction

    // Update the predicted cache state and queue the results of one item.
    task automatic predict_cache(input crsc_pkg::in_item_t it);
        crsc_pkg::out_item_t r;
        int                  w;
        int                  n;
        logic [5:0]          p;
        w = -1;
        if (it.op == crsc_pkg::OP_ACCESS || it.op == crsc_pkg::OP_INVAL) begin
            for (int i = 63; i >= 0; i--) begin
                if (vld[i] && tags[i] == it.sector) w = i;
            end
        end
        case (it.op)
            crsc_pkg::OP_ACCESS: begin
                if (w >= 0) begin
                    hits++;
                    usd[w] = 1'b1;
                    if (it.is_write) drt[w] = 1'b1;
                    r = blank_result();
                    r.hit = 1'b1;
                    r.way = w[5:0];
                end else begin
                    // Second chance sweep: clear use bits until an invalid or unused victim.
                    for (int s = 0; s < 129; s++) begin
                        p = hand;
                        hand = hand + 6'd1;
                        if (vld[p] && usd[p]) begin
                            usd[p] = 1'b0;
                        end else begin
                            w = p;
                            break;
                        end
                    end
                    r = '0;
                    if (vld[w] && drt[w]) begin
                        wbacks++;
                        r.write_back = 1'b1;
                        r.write_back_sector = tags[w];
                    end
                    tags[w] = it.sector;
                    vld[w] = 1'b1;
                    usd[w] = 1'b1;
                    drt[w] = it.is_write;
                    r.way = w[5:0];
                    r.fetch = 1'b1;
                    r.fetch_sector = it.sector;
                    r.hit_total = hits;
                    r.eviction_writes = wbacks;
                    r.last = 1'b1;
                end
                expected_results.push_back(r);
            end
            crsc_pkg::OP_INVAL: begin
                if (w >= 0) begin
                    hits++;
                    vld[w] = 1'b0;
                end
                r = blank_result();
                if (w >= 0) begin
                    r.hit = 1'b1;
                    r.way = w[5:0];
                end
                expected_results.push_back(r);
            end
            crsc_pkg::OP_FLUSH: begin
                n = 0;
                for (int i = 0; i < 64; i++) begin
                    if (vld[i] && drt[i]) begin
                        r = blank_result();
                        r.last = 1'b0;
                        r.way = i[5:0];
                        r.write_back = 1'b1;
                        r.write_back_sector = tags[i];
                        expected_results.push_back(r);
                        n++;
                    end
                end
                if (n > 0) expected_results[$].last = 1'b1;
            end
            default: begin
                vld = '0;
                drt = '0;
                usd = '0;
                hits = '0;
                wbacks = '0;
                expected_results.push_back(blank_result());
            end
        endcase
    endtask

    function automatic crsc_pkg::in_item_t make_item(crsc_pkg::op_e_t op, logic [31:0] sec,
                                                     logic wr);
        crsc_pkg::in_item_t it;
        it.op = op;
        it.sector = sec;
        it.is_write = wr;
        return it;
    endfunction

    function automatic int pick_gap();
        int g;
        g = $urandom_range(0, 99);
        if (g < 50) return 0;
        if (g < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: offers queued items; predicts each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_cycles <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_cache(s_item);
            end
            if (s_valid && !s_ready) begin
                // hold the offered item
            end else if (gap_cycles > 0) begin
                s_valid <= 1'b0;
                gap_cycles <= gap_cycles - 1;
            end else if (pending_items.size() > 0) begin
                s_item <= pending_items.pop_front();
                s_valid <= 1'b1;
                gap_cycles <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares every accepted result with the oldest expectation.
    always @(posedge aclk) begin
        crsc_pkg::out_item_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_cycles <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: %p", m_item);
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_item.hit !== e.hit) begin
                        $error("hit: expected %0h actual %0h", e.hit, m_item.hit);
                        fail_count++;
                    end
                    if (m_item.way !== e.way) begin
                        $error("way: expected %0h actual %0h", e.way, m_item.way);
                        fail_count++;
                    end
                    if (m_item.fetch !== e.fetch) begin
                        $error("fetch: expected %0h actual %0h", e.fetch, m_item.fetch);
                        fail_count++;
                    end
                    if (m_item.fetch_sector !== e.fetch_sector) begin
                        $error("fetch_sector: expected %0h actual %0h",
                               e.fetch_sector, m_item.fetch_sector);
                        fail_count++;
                    end
                    if (m_item.write_back !== e.write_back) begin
                        $error("write_back: expected %0h actual %0h",
                               e.write_back, m_item.write_back);
                        fail_count++;
                    end
                    if (m_item.write_back_sector !== e.write_back_sector) begin
                        $error("write_back_sector: expected %0h actual %0h",
                               e.write_back_sector, m_item.write_back_sector);
                        fail_count++;
                    end
                    if (m_item.hit_total !== e.hit_total) begin
                        $error("hit_total: expected %0h actual %0h",
                               e.hit_total, m_item.hit_total);
                        fail_count++;
                    end
                    if (m_item.eviction_writes !== e.eviction_writes) begin
                        $error("eviction_writes: expected %0h actual %0h",
                               e.eviction_writes, m_item.eviction_writes);
                        fail_count++;
                    end
                    if (m_item.last !== e.last) begin
                        $error("last: expected %0h actual %0h", e.last, m_item.last);
                        fail_count++;
                    end
                end
            end
            // A requested long hold-off wins over the random stalls.
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end else if (stall_cycles > 0) begin
                m_ready <= 1'b0;
                stall_cycles <= stall_cycles - 1;
            end else begin
                m_ready <= 1'b1;
                stall_cycles <= (pending_items.size() % 60 < 20) ? 0 : pick_gap();
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [31:0] pool [16];
        int          r;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        m_ready = 1'b0;
        fail_count = 0;
        hold_cycles = 0;
        stim_done = 1'b0;
        vld = '0;
        drt = '0;
        usd = '0;
        hand = '0;
        hits = '0;
        wbacks = '0;
        foreach (tags[i]) tags[i] = '0;

        // Directed: empty operations, field extremes, hits, write-backs.
        pending_items.push_back(make_item(crsc_pkg::OP_FLUSH, 32'h0, 1'b0));
        pending_items.push_back(make_item(crsc_pkg::OP_INVAL, 32'hFFFF_FFFF, 1'b1));
        pending_items.push_back(make_item(crsc_pkg::OP_ACCESS, 32'h0, 1'b1));
        pending_items.push_back(make_item(crsc_pkg::OP_ACCESS, 32'hFFFF_FFFF, 1'b0));
        pending_items.push_back(make_item(crsc_pkg::OP_ACCESS, 32'h0, 1'b0));
        pending_items.push_back(make_item(crsc_pkg::OP_ACCESS, 32'hFFFF_FFFF, 1'b1));
        pending_items.push_back(make_item(crsc_pkg::OP_ACCESS, 32'hAAAA_5555, 1'b1));
        pending_items.push_back(make_item(crsc_pkg::OP_FLUSH, 32'h1234, 1'b1));
        pending_items.push_back(make_item(crsc_pkg::OP_INVAL, 32'h0, 1'b0));
        pending_items.push_back(make_item(crsc_pkg::OP_INVAL, 32'h0, 1'b0));
        pending_items.push_back(make_item(crsc_pkg::OP_CLEAR, 32'h5555_AAAA, 1'b1));
        pending_items.push_back(make_item(crsc_pkg::OP_ACCESS, 32'hAAAA_5555, 1'b0));
        // Fill all ways dirty, then miss so the hand sweeps a full lap.
        for (int i = 0; i < 64; i++)
            pending_items.push_back(make_item(crsc_pkg::OP_ACCESS, 32'h100 + i, 1'b1));
        pending_items.push_back(make_item(crsc_pkg::OP_ACCESS, 32'h8000_0000, 1'b0));
        pending_items.push_back(make_item(crsc_pkg::OP_FLUSH, 32'h0, 1'b0));

        // Random: accesses on a small sector pool so hits and evictions mix.
        foreach (pool[i]) pool[i] = $urandom();
        for (int i = 0; i < 192; i++) begin
            r = $urandom_range(0, 99);
            if (r < 75)
                pending_items.push_back(make_item(crsc_pkg::OP_ACCESS,
                    ($urandom_range(0, 3) == 0) ? $urandom() : pool[$urandom_range(0, 15)]
                        ^ 32'($urandom_range(0, 80)),
                    1'($urandom())));
            else if (r < 88)
                pending_items.push_back(make_item(crsc_pkg::OP_INVAL,
                    pool[$urandom_range(0, 15)] ^ 32'($urandom_range(0, 80)), 1'($urandom())));
            else if (r < 97)
                pending_items.push_back(make_item(crsc_pkg::OP_FLUSH, $urandom(),
                                                  1'($urandom())));
            else
                pending_items.push_back(make_item(crsc_pkg::OP_CLEAR, $urandom(),
                                                  1'($urandom())));
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Long receiver hold-off while the sender keeps offering items.
        wait (pending_items.size() < 150);
        @(posedge aclk);
        hold_cycles <= 400;

        wait (pending_items.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (400) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/crsc_pkg.sv
rtl/crsc_ram.sv
rtl/crsc_front.sv
rtl/crsc_back.sv
rtl/clock_replacement_sector_cache.sv
verif/clock_replacement_sector_cache_tb.sv
